// ===== src/ittt_pkg.sv =====
// ----------------------------------------------------------------------------
// ittt_pkg
// Shared types and constants of the idle timeout timer table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ittt_pkg;

  localparam int TIME_BITS = 31;
  localparam int ID_BITS   = 8;
  localparam int WORD_BITS = 32;
  localparam int OP_BITS   = 3;
  localparam int STAT_BITS = 3;

  localparam logic [TIME_BITS-1:0] TIME_MAX = 31'h7fffffff;

  typedef enum logic [OP_BITS-1:0] {
    OP_SET_TIME = 3'd0,
    OP_NEW      = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_REFRESH  = 3'd3,
    OP_POLL     = 3'd4
  } op_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_BACKWARDS = 3'd1,
    ST_FULL      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_UNUSED    = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRP,
    S_SLOT,
    S_READ,
    S_EVAL,
    S_LINK_A,
    S_LINK_B,
    S_RESP
  } state_t;

endpackage

// ===== src/ittt_ram.sv =====
// ----------------------------------------------------------------------------
// ittt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ittt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ittt_alloc.sv =====
// ----------------------------------------------------------------------------
// ittt_alloc
// Slot usage map with a two-step search for the lowest free slot: first the
// lowest group of sixteen that is not full, then the lowest free slot in it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ittt_alloc #(
  parameter int NUM_TIMERS = 256,
  parameter int SW         = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          mark_set,
  input  logic          mark_clr,
  input  logic [SW-1:0] mark_idx,
  input  logic          grp_load,
  input  logic [SW-1:0] query_idx,
  output logic          query_used,
  output logic          free_any,
  output logic [SW-1:0] free_slot
);

  import ittt_pkg::*;

  localparam int NG  = (NUM_TIMERS + 15) / 16;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int PAD = NG * 16;

  logic [NUM_TIMERS-1:0] used;
  logic [PAD-1:0]        used_pad;
  logic [NG-1:0]         grp_full;
  logic [GW-1:0]         grp_c;
  logic [GW-1:0]         grp;
  logic [15:0]           row;
  logic [3:0]            low_idx;
  logic [GW+3:0]         slot_wide;

  always_comb begin
    for (int i = 0; i < PAD; i++) begin
      if (i < NUM_TIMERS) begin
        used_pad[i] = used[i];
      end else begin
        used_pad[i] = 1'b1;
      end
    end
    for (int g = 0; g < NG; g++) begin
      grp_full[g] = &used_pad[g*16 +: 16];
    end
    grp_c = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (!grp_full[g]) begin
        grp_c = GW'(g);
      end
    end
  end

  always_comb begin
    row     = used_pad[32'(grp) * 16 +: 16];
    low_idx = '0;
    for (int k = 15; k >= 0; k--) begin
      if (!row[k]) begin
        low_idx = 4'(k);
      end
    end
    slot_wide = {grp, low_idx};
    free_slot = SW'(slot_wide);
  end

  assign query_used = used[query_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      free_any <= 1'b0;
      grp      <= '0;
    end else begin
      if (mark_set) begin
        used[mark_idx] <= 1'b1;
      end else if (mark_clr) begin
        used[mark_idx] <= 1'b0;
      end
      if (grp_load) begin
        grp      <= grp_c;
        free_any <= ~&grp_full;
      end
    end
  end

endmodule

// ===== src/idle_timeout_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// idle_timeout_timer_table_top
// Pool of timers sharing one timeout, kept in a doubly linked list from the
// oldest to the newest arming, with links, expiry and data held in RAMs.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid / cfg_ready  cfg_data (timeout in ticks)
//  in       in         in_valid / in_ready    operation, new_time, timer_id,
//                                             user_data
//  out      out        out_valid / out_ready  status, result_id, result_data
//
//  One operation is in work at a time. Set time, unknown codes and words
//  refused at once go straight to the result stage; an unused slot stops after
//  the read, a full pool after the slot search, remove and poll after evaluation;
//  new timer and refresh then relink. The steps follow from the registered RAM
//  read and the one write per RAM per cycle when list neighbors are relinked.
//  A finished result sits in the output register; the next word is taken
//  while it waits, and the sequencer holds before its result stage.
//  Reset clears the usage map at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idle_timeout_timer_table_top #(
  parameter int NUM_TIMERS = 256,
  parameter int DATA_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ittt_pkg::TIME_BITS-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ittt_pkg::OP_BITS-1:0]      operation,
  input  logic [ittt_pkg::TIME_BITS-1:0]    new_time,
  input  logic [ittt_pkg::ID_BITS-1:0]      timer_id,
  input  logic [ittt_pkg::WORD_BITS-1:0]    user_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ittt_pkg::STAT_BITS-1:0]    status,
  output logic [ittt_pkg::ID_BITS-1:0]      result_id,
  output logic [ittt_pkg::WORD_BITS-1:0]    result_data
);

  import ittt_pkg::*;

  localparam int SW = $clog2(NUM_TIMERS);
  localparam int LW = $clog2(NUM_TIMERS + 1);
  localparam logic [LW-1:0] NIL = LW'(NUM_TIMERS);

  state_t state, state_next;

  logic [TIME_BITS-1:0] timeout, current_time, current_time_next;
  logic [OP_BITS-1:0]   op, op_next;
  logic [DATA_BITS-1:0] data, data_next;
  logic [SW-1:0]        slot, slot_next;
  logic [LW-1:0]        newest, newest_next, oldest, oldest_next;
  logic [LW-1:0]        prev, prev_next;
  status_t              res_status, res_status_next;
  logic [ID_BITS-1:0]   res_id, res_id_next;
  logic [WORD_BITS-1:0] res_data, res_data_next;
  logic                 out_load;

  logic                 newer_we, older_we, exp_we, pay_we;
  logic [SW-1:0]        newer_wa, older_wa;
  logic [LW-1:0]        newer_wd, older_wd;
  logic [LW-1:0]        newer_rd, older_rd;
  logic [TIME_BITS-1:0] exp_rd;
  logic [DATA_BITS-1:0] pay_rd;
  logic [TIME_BITS:0]   exp_sum;
  logic [TIME_BITS-1:0] exp_now;

  logic mark_set, mark_clr, grp_load, query_used, free_any;
  logic [SW-1:0] free_slot;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign exp_sum = {1'b0, current_time} + {1'b0, timeout};
  assign exp_now = exp_sum[TIME_BITS] ? TIME_MAX : exp_sum[TIME_BITS-1:0];

  ittt_alloc #(.NUM_TIMERS(NUM_TIMERS), .SW(SW)) u_alloc (
    .clk(clk), .rst(rst), .mark_set(mark_set), .mark_clr(mark_clr), .mark_idx(slot),
    .grp_load(grp_load), .query_idx(slot), .query_used(query_used),
    .free_any(free_any), .free_slot(free_slot)
  );

  ittt_ram #(.WIDTH(LW), .DEPTH(NUM_TIMERS)) u_newer (
    .clk(clk), .we(newer_we), .waddr(newer_wa), .wdata(newer_wd),
    .raddr(slot), .rdata(newer_rd)
  );

  ittt_ram #(.WIDTH(LW), .DEPTH(NUM_TIMERS)) u_older (
    .clk(clk), .we(older_we), .waddr(older_wa), .wdata(older_wd),
    .raddr(slot), .rdata(older_rd)
  );

  ittt_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_TIMERS)) u_expiry (
    .clk(clk), .we(exp_we), .waddr(slot), .wdata(exp_now),
    .raddr(slot), .rdata(exp_rd)
  );

  ittt_ram #(.WIDTH(DATA_BITS), .DEPTH(NUM_TIMERS)) u_payload (
    .clk(clk), .we(pay_we), .waddr(slot), .wdata(data),
    .raddr(slot), .rdata(pay_rd)
  );

  always_comb begin
    state_next        = state;
    current_time_next = current_time;
    op_next           = op;
    data_next         = data;
    slot_next         = slot;
    newest_next       = newest;
    oldest_next       = oldest;
    prev_next         = prev;
    res_status_next   = res_status;
    res_id_next       = res_id;
    res_data_next     = res_data;
    newer_we = 1'b0;
    newer_wa = slot;
    newer_wd = NIL;
    older_we = 1'b0;
    older_wa = slot;
    older_wd = newest;
    exp_we   = 1'b0;
    pay_we   = 1'b0;
    mark_set = 1'b0;
    mark_clr = 1'b0;
    grp_load = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next         = operation;
          data_next       = DATA_BITS'(user_data);
          res_status_next = ST_OK;
          res_id_next     = '0;
          res_data_next   = '0;
          state_next      = S_RESP;
          case (operation)
            OP_SET_TIME: begin
              if (new_time < current_time) begin
                res_status_next = ST_BACKWARDS;
              end else begin
                current_time_next = new_time;
              end
            end
            OP_NEW: begin
              state_next = S_GRP;
            end
            OP_REMOVE, OP_REFRESH: begin
              if (32'(timer_id) < 32'(NUM_TIMERS)) begin
                slot_next  = SW'(timer_id);
                state_next = S_READ;
              end else begin
                res_status_next = ST_RANGE;
              end
            end
            OP_POLL: begin
              if (oldest < NIL) begin
                slot_next  = SW'(oldest);
                state_next = S_READ;
              end else begin
                res_status_next = ST_NONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_GRP: begin
        grp_load   = 1'b1;
        state_next = S_SLOT;
      end
      S_SLOT: begin
        if (free_any) begin
          slot_next   = free_slot;
          res_id_next = ID_BITS'(free_slot);
          state_next  = S_LINK_A;
        end else begin
          res_status_next = ST_FULL;
          state_next      = S_RESP;
        end
      end
      S_READ: begin
        if (op != OP_POLL && !query_used) begin
          res_status_next = ST_UNUSED;
          state_next      = S_RESP;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (op == OP_POLL && current_time < exp_rd) begin
          res_status_next = ST_NONE;
          state_next      = S_RESP;
        end else begin
          if (older_rd < NIL) begin
            newer_we = 1'b1;
            newer_wa = SW'(older_rd);
            newer_wd = newer_rd;
          end else begin
            oldest_next = (newer_rd < NIL) ? newer_rd : NIL;
          end
          if (newer_rd < NIL) begin
            older_we = 1'b1;
            older_wa = SW'(newer_rd);
            older_wd = older_rd;
          end else begin
            newest_next = (older_rd < NIL) ? older_rd : NIL;
          end
          if (op == OP_REFRESH) begin
            state_next = S_LINK_A;
          end else begin
            mark_clr   = 1'b1;
            state_next = S_RESP;
            if (op == OP_POLL) begin
              res_id_next   = ID_BITS'(slot);
              res_data_next = WORD_BITS'(pay_rd);
            end
          end
        end
      end
      S_LINK_A: begin
        older_we = 1'b1;
        older_wa = slot;
        older_wd = newest;
        newer_we = 1'b1;
        newer_wa = slot;
        newer_wd = NIL;
        exp_we   = 1'b1;
        if (op == OP_NEW) begin
          pay_we   = 1'b1;
          mark_set = 1'b1;
        end
        prev_next   = newest;
        newest_next = LW'(slot);
        if (!(oldest < NIL)) begin
          oldest_next = LW'(slot);
        end
        state_next = S_LINK_B;
      end
      S_LINK_B: begin
        if (prev < NIL) begin
          newer_we = 1'b1;
          newer_wa = SW'(prev);
          newer_wd = LW'(slot);
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      timeout      <= TIME_BITS'(1);
      current_time <= '0;
      newest       <= NIL;
      oldest       <= NIL;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      current_time <= current_time_next;
      newest       <= newest_next;
      oldest       <= oldest_next;
      if (cfg_valid && cfg_ready) begin
        timeout <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    data       <= data_next;
    slot       <= slot_next;
    prev       <= prev_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    res_data   <= res_data_next;
    if (out_load) begin
      status      <= res_status;
      result_id   <= res_id;
      result_data <= res_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    (oldest < NIL) == (newest < NIL))
    else $error("oldest and newest disagree on an empty list");

  a_time_forward: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> current_time >= $past(current_time))
    else $error("current time moved backwards");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("sequencer idle right after taking a word");

  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    !(mark_set && mark_clr))
    else $error("slot marked used and free at once");
`endif

endmodule

// ===== dv/idle_timeout_timer_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// idle_timeout_timer_table_top_tb
// Drives timer table operations with random gaps on both channels, keeps its
// own copy of the linked timer list and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idle_timeout_timer_table_top_tb;
  import ittt_pkg::*;

  localparam int NTIM = 256;
  localparam int NIL = NTIM;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [STAT_BITS-1:0] st;
    logic [ID_BITS-1:0]   id;
    logic [WORD_BITS-1:0] data;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TIME_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_BITS-1:0] operation = '0;
  logic [TIME_BITS-1:0] new_time = '0;
  logic [ID_BITS-1:0] timer_id = '0;
  logic [WORD_BITS-1:0] user_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_BITS-1:0] status;
  logic [ID_BITS-1:0] result_id;
  logic [WORD_BITS-1:0] result_data;

  bit timer_used [NTIM];
  int timer_newer [NTIM];
  int timer_older [NTIM];
  logic [TIME_BITS-1:0] timer_expiry [NTIM];
  logic [WORD_BITS-1:0] timer_data [NTIM];
  int head_new = NIL;
  int head_old = NIL;
  logic [TIME_BITS-1:0] now_ticks = '0;
  logic [TIME_BITS-1:0] timeout_val = 1;

  answer_t pending_answers[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  int long_hold = 0;

  idle_timeout_timer_table_top i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("** idle_timeout_timer_table_top: FAILED **");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report("unexpected word", status, 0);
      end else begin
        answer_t a;
        a = pending_answers.pop_front();
        if (status !== a.st) report("status", status, a.st);
        if (result_id !== a.id) report("result_id", result_id, a.id);
        if (result_data !== a.data) report("result_data", result_data, a.data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (($urandom % 4) == 0) begin
      hold_off <= ($urandom % 10 == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [TIME_BITS-1:0] armed_expiry();
    logic [TIME_BITS:0] sum;
    sum = {1'b0, now_ticks} + {1'b0, timeout_val};
    return sum > {1'b0, TIME_MAX} ? TIME_MAX : sum[TIME_BITS-1:0];
  endfunction

  function automatic void detach_timer(int s);
    int o, n;
    o = timer_older[s];
    n = timer_newer[s];
    if (o < NTIM) timer_newer[o] = n;
    else head_old = n;
    if (n < NTIM) timer_older[n] = o;
    else head_new = o;
  endfunction

  function automatic void append_newest(int s);
    timer_older[s] = head_new;
    timer_newer[s] = NIL;
    if (head_new < NTIM) timer_newer[head_new] = s;
    head_new = s;
    if (head_old >= NTIM) head_old = s;
  endfunction

  function automatic answer_t table_outcome(logic [2:0] op, logic [TIME_BITS-1:0] t,
                                            logic [7:0] id, logic [31:0] d);
    answer_t a;
    int s;
    a = '0;
    a.st = ST_OK;
    case (op)
      OP_SET_TIME: begin
        if (t < now_ticks) a.st = ST_BACKWARDS;
        else now_ticks = t;
      end
      OP_NEW: begin
        s = 0;
        while (s < NTIM && timer_used[s]) s++;
        if (s >= NTIM) begin
          a.st = ST_FULL;
        end else begin
          timer_used[s] = 1'b1;
          timer_data[s] = d;
          timer_expiry[s] = armed_expiry();
          append_newest(s);
          a.id = ID_BITS'(s);
        end
      end
      OP_REMOVE, OP_REFRESH: begin
        if (!timer_used[id]) begin
          a.st = ST_UNUSED;
        end else begin
          detach_timer(id);
          if (op == OP_REMOVE) begin
            timer_used[id] = 1'b0;
          end else begin
            timer_expiry[id] = armed_expiry();
            append_newest(id);
          end
        end
      end
      OP_POLL: begin
        s = head_old;
        if (s >= NTIM || now_ticks < timer_expiry[s]) begin
          a.st = ST_NONE;
        end else begin
          detach_timer(s);
          timer_used[s] = 1'b0;
          a.id = ID_BITS'(s);
          a.data = timer_data[s];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_op(input logic [2:0] op, input logic [TIME_BITS-1:0] t,
                         input logic [7:0] id, input logic [31:0] d, input bit gaps = 1);
    int gap;
    gap = 0;
    if (gaps && ($urandom % 3) == 0)
      gap = ($urandom % 12 == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    new_time <= t;
    timer_id <= id;
    user_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_answers.push_back(table_outcome(op, t, id, d));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIME_BITS-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    timeout_val = v;
  endtask

  function automatic logic [7:0] pick_id();
    int s;
    if (($urandom % 8) != 0) begin
      s = $urandom_range(0, NTIM - 1);
      repeat (8) begin
        if (timer_used[s]) return ID_BITS'(s);
        s = $urandom_range(0, NTIM - 1);
      end
    end
    return ID_BITS'($urandom);
  endfunction

  task automatic test_directed();
    send_op(OP_POLL, 0, 0, 0);
    send_op(OP_REMOVE, 0, 8'hff, 0);
    send_op(OP_REFRESH, 0, 8'h00, 0);
    send_op(OP_NEW, 0, 0, 32'hffff_ffff);
    send_op(OP_NEW, 0, 0, 32'h0000_0000);
    send_op(OP_NEW, 0, 0, 32'ha5a5_5a5a);
    send_op(OP_POLL, 0, 0, 0);
    send_op(OP_SET_TIME, 1, 0, 0);
    send_op(OP_REFRESH, 0, 0, 0);
    send_op(OP_POLL, 0, 0, 0);
    send_op(OP_REMOVE, 0, 1, 0);
    send_op(OP_REMOVE, 0, 1, 0);
    send_op(3'd5, 31'h5555_5555, 8'haa, 32'h1234_5678);
    send_op(3'd6, 0, 0, 0);
    send_op(3'd7, TIME_MAX, 8'hff, 32'hffff_ffff);
    send_op(OP_SET_TIME, 0, 0, 0);
    send_op(OP_SET_TIME, 2, 0, 0);
    send_op(OP_POLL, 0, 0, 0);
    send_op(OP_POLL, 0, 0, 0);
    send_op(OP_POLL, 0, 0, 0);
  endtask

  task automatic test_saturation();
    write_timeout(TIME_MAX);
    send_op(OP_NEW, 0, 0, 32'h0bad_cafe);
    send_op(OP_SET_TIME, TIME_MAX - 1, 0, 0);
    send_op(OP_POLL, 0, 0, 0);
    send_op(OP_SET_TIME, TIME_MAX, 0, 0);
    send_op(OP_POLL, 0, 0, 0);
    send_op(OP_SET_TIME, 0, 0, 0);
  endtask

  task automatic test_pool_full();
    write_timeout(0);
    long_hold = 80;
    for (int i = 0; i < NTIM + 2; i++) begin
      send_op(OP_NEW, 0, 0, $urandom, 0);
    end
    for (int i = 0; i < 40; i++) send_op(OP_REMOVE, 0, ID_BITS'($urandom), 0);
    send_op(OP_NEW, 0, 0, $urandom);
    for (int i = 0; i < NTIM + 1; i++) send_op(OP_POLL, 0, 0, 0, i > 100);
  endtask

  task automatic test_random(input logic [TIME_BITS-1:0] tmo, input int count);
    logic [TIME_BITS-1:0] t;
    int r;
    write_timeout(tmo);
    for (int i = 0; i < count; i++) begin
      r = $urandom % 100;
      if (r < 25) begin
        send_op(OP_NEW, $urandom, $urandom, $urandom);
      end else if (r < 40) begin
        send_op(OP_REMOVE, $urandom, pick_id(), $urandom);
      end else if (r < 55) begin
        send_op(OP_REFRESH, $urandom, pick_id(), $urandom);
      end else if (r < 78) begin
        send_op(OP_POLL, $urandom, $urandom, $urandom);
      end else if (r < 96) begin
        if (($urandom % 10) == 0) t = $urandom;
        else if (($urandom % 20) == 0) t = TIME_MAX;
        else t = (now_ticks > TIME_MAX - 40) ? now_ticks : now_ticks + $urandom_range(0, 40);
        if (($urandom % 8) == 0 && now_ticks > 0) t = now_ticks - 1;
        send_op(OP_SET_TIME, t, $urandom, $urandom);
      end else begin
        send_op(OP_BITS'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
      end
      if (i == count / 2) drain();
    end
  endtask

  task automatic test_reset_time();
    drain();
    rst <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_pool_full();
    test_random(5, 300);
    test_random(0, 200);
    test_random(1, 200);
    test_random(31'h4000_0000, 150);
    test_random(TIME_MAX - 3, 150);
    test_random(12, 200);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("** idle_timeout_timer_table_top: PASSED **");
    else
      $display("** idle_timeout_timer_table_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ittt_pkg.sv
src/ittt_ram.sv
src/ittt_alloc.sv
src/idle_timeout_timer_table_top.sv
dv/idle_timeout_timer_table_top_tb.sv
